[sv/monospace_word_wrap_line_breaker_macros.svh]
//------------------------------------------------------------------------------
// Assertion macros for the monospace word wrap line breaker
// Shorthands for clocked implication checks that are disabled during reset.
//------------------------------------------------------------------------------
`ifndef MONOSPACE_WORD_WRAP_LINE_BREAKER_MACROS_SVH
`define MONOSPACE_WORD_WRAP_LINE_BREAKER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define MWWLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define MWWLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mwwlb_pkg.sv]
//------------------------------------------------------------------------------
// Monospace word wrap line breaker package
// Payload types, field widths, codes and reset values shared by the block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwwlb_pkg;

	// Fixed widths of the transaction fields.
	localparam int unsigned POS_W   = 24;
	localparam int unsigned LEN_W   = 3;
	localparam int unsigned CLASS_W = 2;
	localparam int unsigned LINE_Y_W = 16;

	// Pen x is kept in 13 bits and saturates.
	localparam int unsigned PEN_X_W = 13;
	localparam logic [PEN_X_W-1:0] PEN_X_MAX = '1;

	// Configuration register widths and port layout.
	localparam int unsigned WRAP_W    = 12;
	localparam int unsigned MARGIN_W  = 12;
	localparam int unsigned ADVANCE_W = 7;
	localparam int unsigned PITCH_W   = 8;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned CFG_INDEX_W = 3;

	// Default storage widths.
	localparam int unsigned OFFSET_BITS_DEF = 24;
	localparam int unsigned COORD_BITS_DEF  = 16;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WRAP_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_MARGIN  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP_MARGIN   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHAR_ADVANCE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH   = 3'd4;

	// Register reset values.
	localparam logic [WRAP_W-1:0]    WRAP_WIDTH_RST   = 12'd320;
	localparam logic [MARGIN_W-1:0]  LEFT_MARGIN_RST  = 12'd0;
	localparam logic [MARGIN_W-1:0]  TOP_MARGIN_RST   = 12'd0;
	localparam logic [ADVANCE_W-1:0] CHAR_ADVANCE_RST = 7'd8;
	localparam logic [PITCH_W-1:0]   LINE_PITCH_RST   = 8'd16;

	// Item kinds and character classes.
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;
	localparam logic [CLASS_W-1:0] CLASS_ORDINARY = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_SPACE    = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_NEWLINE  = 2'd2;

	typedef struct packed {
		logic               kind;
		logic [CLASS_W-1:0] char_class;
		logic [POS_W-1:0]   byte_pos;
		logic [LEN_W-1:0]   byte_len;
	} mwwlb_in_t;

	typedef struct packed {
		logic [POS_W-1:0]    line_first_byte;
		logic [POS_W-1:0]    line_end_byte;
		logic [LINE_Y_W-1:0] line_y;
		logic                hard_break;
		logic                final_line;
	} mwwlb_out_t;

endpackage

[sv/monospace_word_wrap_line_breaker.sv]
//------------------------------------------------------------------------------
// Monospace word wrap line breaker
// Greedy line breaking over a stream of decoded characters, one per cycle unless out stalls.
//------------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Payload
//   in        in    in_valid / in_ready    in_data  (mwwlb_in_t, one character or end)
//   out       out   out_valid / out_ready  out_data (mwwlb_out_t, one line record)
//   cfg       in    cfg_wr_en              cfg_index, cfg_data (write only)
//
// Every transaction passes through the input register and leaves its line
// record, if any, in the result register when it is processed.
// One transaction is accepted per cycle unless out stalls; pen state is registered.
// A stall on out holds the result register; one more transaction still enters
// the input register, after which in_ready drops until out_ready returns.
// Reset is asynchronous, takes effect at once and needs no clearing pass.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "monospace_word_wrap_line_breaker_macros.svh"

module monospace_word_wrap_line_breaker
	import mwwlb_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mwwlb_in_t              in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mwwlb_out_t             out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Width of the product chars_after_space * char_advance.
	localparam int unsigned PROD_W = PEN_X_W + ADVANCE_W;

	// Configuration registers. The user must change them only while the block is idle; the block does not enforce it.
	logic [WRAP_W-1:0]    wrap_limit_q;
	logic [MARGIN_W-1:0]  left_margin_q;
	logic [MARGIN_W-1:0]  top_margin_q;
	logic [ADVANCE_W-1:0] char_advance_q;
	logic [PITCH_W-1:0]   line_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q   <= WRAP_WIDTH_RST;
			left_margin_q  <= LEFT_MARGIN_RST;
			top_margin_q   <= TOP_MARGIN_RST;
			char_advance_q <= CHAR_ADVANCE_RST;
			line_pitch_q   <= LINE_PITCH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WRAP_WIDTH:   wrap_limit_q   <= cfg_data[WRAP_W-1:0];
				REG_LEFT_MARGIN:  left_margin_q  <= cfg_data[MARGIN_W-1:0];
				REG_TOP_MARGIN:   top_margin_q   <= cfg_data[MARGIN_W-1:0];
				REG_CHAR_ADVANCE: char_advance_q <= cfg_data[ADVANCE_W-1:0];
				REG_LINE_PITCH:   line_pitch_q   <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register. It is free when empty or when its transaction is being
	// processed this cycle, so a stalled result blocks the next input only once it is full.
	mwwlb_in_t item_s1;
	logic      valid_s1;
	logic      advance;
	logic      out_valid_q;
	mwwlb_out_t out_data_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Pen and line state.
	logic [PEN_X_W-1:0]     pen_x_q;
	logic [COORD_BITS-1:0]  pen_y_q;
	logic [OFFSET_BITS-1:0] row_start_q;
	logic                   space_seen_q;
	logic [OFFSET_BITS-1:0] space_offset_q;
	logic [PEN_X_W-1:0]     chars_after_space_q;

	logic [PEN_X_W-1:0]     pen_x_d;
	logic [COORD_BITS-1:0]  pen_y_d;
	logic [OFFSET_BITS-1:0] row_start_d;
	logic                   space_seen_d;
	logic [OFFSET_BITS-1:0] space_offset_d;
	logic [PEN_X_W-1:0]     chars_after_space_d;

	logic                   emit;
	mwwlb_out_t             rec;

	// Datapath pieces shared by the branches below.
	logic [OFFSET_BITS-1:0] pos;
	logic [COORD_BITS:0]    y_sum;
	logic [COORD_BITS-1:0]  y_next;
	logic [PEN_X_W:0]       x_sum;
	logic [PEN_X_W-1:0]     x_adv;
	logic [PEN_X_W-1:0]     cas_upd;
	logic [PROD_W-1:0]      span_prod;
	logic [PROD_W:0]        span_sum;
	logic [PEN_X_W-1:0]     x_after_space;
	logic [PEN_X_W-1:0]     x_after_char;
	logic                   is_space;
	logic                   space_seen_upd;
	logic [OFFSET_BITS-1:0] space_offset_upd;

	assign pos = OFFSET_BITS'(item_s1.byte_pos);

	// Next row, saturating at the top of the coordinate range.
	assign y_sum  = {1'b0, pen_y_q} + (COORD_BITS + 1)'(line_pitch_q);
	assign y_next = y_sum[COORD_BITS] ? '1 : y_sum[COORD_BITS-1:0];

	// Class 3 falls through as an ordinary character.
	assign is_space         = (item_s1.char_class == CLASS_SPACE);
	assign space_seen_upd   = space_seen_q || is_space;
	assign space_offset_upd = is_space ? pos : space_offset_q;
	assign cas_upd          = is_space ? '0 :
	                          (chars_after_space_q == PEN_X_MAX) ? PEN_X_MAX :
	                          chars_after_space_q + PEN_X_W'(1);

	// Pen advance, saturating.
	assign x_sum = {1'b0, pen_x_q} + (PEN_X_W + 1)'(char_advance_q);
	assign x_adv = x_sum[PEN_X_W] ? PEN_X_MAX : x_sum[PEN_X_W-1:0];

	// Pen x after a break at the last space: the word carried over to the new line.
	assign span_prod     = PROD_W'(cas_upd) * PROD_W'(char_advance_q);
	assign span_sum      = (PROD_W + 1)'(left_margin_q) + {1'b0, span_prod};
	assign x_after_space = (span_sum > (PROD_W + 1)'(PEN_X_MAX)) ? PEN_X_MAX :
	                       span_sum[PEN_X_W-1:0];
	// Pen x after a break before the overflowing character; this cannot saturate.
	assign x_after_char  = PEN_X_W'(left_margin_q) + PEN_X_W'(char_advance_q);

	always_comb begin
		pen_x_d             = pen_x_q;
		pen_y_d             = pen_y_q;
		row_start_d         = row_start_q;
		space_seen_d        = space_seen_q;
		space_offset_d      = space_offset_q;
		chars_after_space_d = chars_after_space_q;
		emit                = 1'b0;
		rec.line_first_byte = POS_W'(row_start_q);
		rec.line_end_byte   = POS_W'(pos);
		rec.line_y          = LINE_Y_W'(pen_y_q);
		rec.hard_break      = 1'b0;
		rec.final_line      = 1'b0;

		if (item_s1.kind == KIND_END) begin
			// Close the last line and rewind to the start of a new text.
			emit                = 1'b1;
			rec.final_line      = 1'b1;
			pen_x_d             = PEN_X_W'(left_margin_q);
			pen_y_d             = COORD_BITS'(top_margin_q);
			row_start_d         = '0;
			space_seen_d        = 1'b0;
			space_offset_d      = '0;
			chars_after_space_d = '0;
		end else if (item_s1.char_class == CLASS_NEWLINE) begin
			// Hard break; the next line starts just past the newline.
			emit                = 1'b1;
			rec.hard_break      = 1'b1;
			row_start_d         = pos + OFFSET_BITS'(item_s1.byte_len);
			pen_x_d             = PEN_X_W'(left_margin_q);
			pen_y_d             = y_next;
			space_seen_d        = 1'b0;
			chars_after_space_d = '0;
		end else begin
			space_offset_d = space_offset_upd;
			if (x_adv <= PEN_X_W'(wrap_limit_q)) begin
				// Still fits on the current line.
				pen_x_d             = x_adv;
				space_seen_d        = space_seen_upd;
				chars_after_space_d = cas_upd;
			end else begin
				emit                = 1'b1;
				pen_y_d             = y_next;
				space_seen_d        = 1'b0;
				chars_after_space_d = '0;
				if (space_seen_upd) begin
					// Soft break at the last space; the space itself is dropped.
					rec.line_end_byte = POS_W'(space_offset_upd);
					row_start_d       = space_offset_upd + OFFSET_BITS'(1);
					pen_x_d           = x_after_space;
				end else begin
					// No space on this line: break before the overflowing character.
					row_start_d = pos;
					pen_x_d     = x_after_char;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q             <= PEN_X_W'(LEFT_MARGIN_RST);
			pen_y_q             <= COORD_BITS'(TOP_MARGIN_RST);
			row_start_q         <= '0;
			space_seen_q        <= 1'b0;
			space_offset_q      <= '0;
			chars_after_space_q <= '0;
		end else if (advance) begin
			pen_x_q             <= pen_x_d;
			pen_y_q             <= pen_y_d;
			row_start_q         <= row_start_d;
			space_seen_q        <= space_seen_d;
			space_offset_q      <= space_offset_d;
			chars_after_space_q <= chars_after_space_d;
		end
	end

	// Result register. It loads only when it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= rec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks on the block's own control and state.
	`MWWLB_ASSERT_IMP(a_ready_only_on_stall, clk, arst_n, !in_ready,
		valid_s1 && out_valid_q && !out_ready, "input blocked without an output stall")
	`MWWLB_ASSERT_NXT(a_emit_lands, clk, arst_n, advance && emit,
		out_valid_q, "line record lost on its way to the result register")
	`MWWLB_ASSERT_NXT(a_end_rewinds, clk, arst_n, advance && item_s1.kind == KIND_END,
		!space_seen_q && row_start_q == '0 && chars_after_space_q == '0,
		"state not rewound after the end transaction")
	`MWWLB_ASSERT_IMP(a_break_kinds_exclusive, clk, arst_n, out_valid_q,
		!(out_data_q.hard_break && out_data_q.final_line),
		"line record flagged both hard break and final line")

endmodule
